// File: hdl/qrv_pkg.sv
// Package for the quaternion vector rotation pipeline.
// Holds the fixed-point widths, rounding constants and shared datapath types.
// No dependencies.
package qrv_pkg;

  localparam int Q_W       = 16;
  localparam int VEC_W     = 24;
  localparam int QPROD_W   = 2 * Q_W;
  localparam int MAT_W     = QPROD_W + 2;
  localparam int PROD_W    = MAT_W + VEC_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_BITS = 28;
  localparam int RND_W     = ACC_W - FRAC_BITS;

  localparam logic signed [MAT_W-1:0] MAT_ONE    = 34'sd268435456;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 60'sd134217728;
  localparam logic signed [RND_W-1:0] RND_MAX    = 32'sd8388607;
  localparam logic signed [RND_W-1:0] RND_MIN    = -32'sd8388608;
  localparam logic signed [VEC_W-1:0] OUT_MAX    = 24'sh7fffff;
  localparam logic signed [VEC_W-1:0] OUT_MIN    = 24'sh800000;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] m00;
    logic signed [MAT_W-1:0] m01;
    logic signed [MAT_W-1:0] m02;
    logic signed [MAT_W-1:0] m10;
    logic signed [MAT_W-1:0] m11;
    logic signed [MAT_W-1:0] m12;
    logic signed [MAT_W-1:0] m20;
    logic signed [MAT_W-1:0] m21;
    logic signed [MAT_W-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] c0;
    logic signed [MAT_W-1:0] c1;
    logic signed [MAT_W-1:0] c2;
  } row_t;

endpackage

// File: hdl/qrv_matrix.sv
// Rotation matrix generator: two register stages.
// Stage one forms the nine quaternion products, stage two the Q.28 matrix entries.
// Depends on qrv_pkg.
module qrv_matrix (
  input  logic                                clk,
  input  logic signed [qrv_pkg::Q_W-1:0]      quat_w,
  input  logic signed [qrv_pkg::Q_W-1:0]      quat_x,
  input  logic signed [qrv_pkg::Q_W-1:0]      quat_y,
  input  logic signed [qrv_pkg::Q_W-1:0]      quat_z,
  input  qrv_pkg::vec_t                       vec_in,
  output qrv_pkg::mat_t                       mat,
  output qrv_pkg::vec_t                       vec_out
);

  localparam int PW = qrv_pkg::QPROD_W;
  localparam int MW = qrv_pkg::MAT_W;

  logic signed [PW-1:0] xx_nxt, yy_nxt, zz_nxt, xy_nxt, xz_nxt, yz_nxt;
  logic signed [PW-1:0] wx_nxt, wy_nxt, wz_nxt;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  qrv_pkg::vec_t        vec1_r, vec2_r;
  qrv_pkg::mat_t        mat_nxt, mat_r;

  assign xx_nxt = PW'(quat_x) * PW'(quat_x);
  assign yy_nxt = PW'(quat_y) * PW'(quat_y);
  assign zz_nxt = PW'(quat_z) * PW'(quat_z);
  assign xy_nxt = PW'(quat_x) * PW'(quat_y);
  assign xz_nxt = PW'(quat_x) * PW'(quat_z);
  assign yz_nxt = PW'(quat_y) * PW'(quat_z);
  assign wx_nxt = PW'(quat_w) * PW'(quat_x);
  assign wy_nxt = PW'(quat_w) * PW'(quat_y);
  assign wz_nxt = PW'(quat_w) * PW'(quat_z);

  always_ff @(posedge clk) begin
    xx_r   <= xx_nxt;
    yy_r   <= yy_nxt;
    zz_r   <= zz_nxt;
    xy_r   <= xy_nxt;
    xz_r   <= xz_nxt;
    yz_r   <= yz_nxt;
    wx_r   <= wx_nxt;
    wy_r   <= wy_nxt;
    wz_r   <= wz_nxt;
    vec1_r <= vec_in;
  end

  // Every entry carries the factor of two from the doubled products.
  always_comb begin
    mat_nxt.m00 = qrv_pkg::MAT_ONE - ((MW'(yy_r) + MW'(zz_r)) <<< 1);
    mat_nxt.m01 = (MW'(xy_r) - MW'(wz_r)) <<< 1;
    mat_nxt.m02 = (MW'(xz_r) + MW'(wy_r)) <<< 1;
    mat_nxt.m10 = (MW'(xy_r) + MW'(wz_r)) <<< 1;
    mat_nxt.m11 = qrv_pkg::MAT_ONE - ((MW'(xx_r) + MW'(zz_r)) <<< 1);
    mat_nxt.m12 = (MW'(yz_r) - MW'(wx_r)) <<< 1;
    mat_nxt.m20 = (MW'(xz_r) - MW'(wy_r)) <<< 1;
    mat_nxt.m21 = (MW'(yz_r) + MW'(wx_r)) <<< 1;
    mat_nxt.m22 = qrv_pkg::MAT_ONE - ((MW'(xx_r) + MW'(yy_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    mat_r  <= mat_nxt;
    vec2_r <= vec1_r;
  end

  assign mat     = mat_r;
  assign vec_out = vec2_r;

endmodule

// File: hdl/qrv_row.sv
// One output component: two register stages.
// Stage one holds the three matrix-times-vector products, stage two the rounded,
// saturated sum. Depends on qrv_pkg.
module qrv_row (
  input  logic                                clk,
  input  qrv_pkg::row_t                       coef,
  input  qrv_pkg::vec_t                       vec,
  output logic signed [qrv_pkg::VEC_W-1:0]    rot,
  output logic                                sat
);

  localparam int PW = qrv_pkg::PROD_W;
  localparam int AW = qrv_pkg::ACC_W;
  localparam int RW = qrv_pkg::RND_W;
  localparam int VW = qrv_pkg::VEC_W;

  logic signed [PW-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic signed [AW-1:0] acc;
  logic signed [RW-1:0] rnd;
  logic signed [VW-1:0] rot_nxt, rot_r;
  logic                 sat_nxt, sat_r;

  assign p0_nxt = PW'(coef.c0) * PW'(vec.x);
  assign p1_nxt = PW'(coef.c1) * PW'(vec.y);
  assign p2_nxt = PW'(coef.c2) * PW'(vec.z);

  always_ff @(posedge clk) begin
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end

  // Adding one half and dropping the fraction rounds ties toward plus infinity.
  always_comb begin
    acc = AW'(p0_r) + AW'(p1_r) + AW'(p2_r) + qrv_pkg::ROUND_HALF;
    rnd = acc[AW-1:qrv_pkg::FRAC_BITS];
    if (rnd > qrv_pkg::RND_MAX) begin
      rot_nxt = qrv_pkg::OUT_MAX;
      sat_nxt = 1'b1;
    end else if (rnd < qrv_pkg::RND_MIN) begin
      rot_nxt = qrv_pkg::OUT_MIN;
      sat_nxt = 1'b1;
    end else begin
      rot_nxt = rnd[VW-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
    sat_r <= sat_nxt;
  end

  assign rot = rot_r;
  assign sat = sat_r;

endmodule

// File: hdl/quaternion_rotate_vector.sv
// out_valid goes high with the result once a transaction accepted at a clock edge has
// passed the rounding stage. Throughput: one transaction per cycle; the four-stage
// pipeline of quaternion products, matrix entries, vector products and rounding
// never stalls, so busy stays low. Reset clears the valid bits of every stage.
// Depends on qrv_pkg, qrv_matrix and qrv_row.
module quaternion_rotate_vector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [qrv_pkg::Q_W-1:0]      in_quat_w,
  input  logic signed [qrv_pkg::Q_W-1:0]      in_quat_x,
  input  logic signed [qrv_pkg::Q_W-1:0]      in_quat_y,
  input  logic signed [qrv_pkg::Q_W-1:0]      in_quat_z,
  input  logic signed [qrv_pkg::VEC_W-1:0]    in_vec_x,
  input  logic signed [qrv_pkg::VEC_W-1:0]    in_vec_y,
  input  logic signed [qrv_pkg::VEC_W-1:0]    in_vec_z,
  output logic                                out_valid,
  output logic signed [qrv_pkg::VEC_W-1:0]    out_rot_x,
  output logic signed [qrv_pkg::VEC_W-1:0]    out_rot_y,
  output logic signed [qrv_pkg::VEC_W-1:0]    out_rot_z,
  output logic                                out_saturated
);

  logic          accept;
  logic          valid1_r, valid2_r, valid3_r, valid4_r;
  qrv_pkg::vec_t vec_in, vec_mat;
  qrv_pkg::mat_t mat;
  qrv_pkg::row_t row0, row1, row2;
  logic          sat0, sat1, sat2;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
      valid4_r <= 1'b0;
    end else begin
      valid1_r <= accept;
      valid2_r <= valid1_r;
      valid3_r <= valid2_r;
      valid4_r <= valid3_r;
    end
  end

  assign vec_in = '{x: in_vec_x, y: in_vec_y, z: in_vec_z};

  qrv_matrix u_matrix (
    .clk     (clk),
    .quat_w  (in_quat_w),
    .quat_x  (in_quat_x),
    .quat_y  (in_quat_y),
    .quat_z  (in_quat_z),
    .vec_in  (vec_in),
    .mat     (mat),
    .vec_out (vec_mat)
  );

  assign row0 = '{c0: mat.m00, c1: mat.m01, c2: mat.m02};
  assign row1 = '{c0: mat.m10, c1: mat.m11, c2: mat.m12};
  assign row2 = '{c0: mat.m20, c1: mat.m21, c2: mat.m22};

  qrv_row u_row_x (
    .clk  (clk),
    .coef (row0),
    .vec  (vec_mat),
    .rot  (out_rot_x),
    .sat  (sat0)
  );

  qrv_row u_row_y (
    .clk  (clk),
    .coef (row1),
    .vec  (vec_mat),
    .rot  (out_rot_y),
    .sat  (sat1)
  );

  qrv_row u_row_z (
    .clk  (clk),
    .coef (row2),
    .vec  (vec_mat),
    .rot  (out_rot_z),
    .sat  (sat2)
  );

  assign out_valid     = valid4_r;
  assign out_saturated = sat0 || sat1 || sat2;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted transaction did not produce a result after four cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result strobe without a matching transaction");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_rot_x == qrv_pkg::OUT_MAX || out_rot_x == qrv_pkg::OUT_MIN ||
       out_rot_y == qrv_pkg::OUT_MAX || out_rot_y == qrv_pkg::OUT_MIN ||
       out_rot_z == qrv_pkg::OUT_MAX || out_rot_z == qrv_pkg::OUT_MIN))
    else $error("saturation flagged but no component is at a limit");

endmodule

// File: sim/tb_quaternion_rotate_vector.sv
`timescale 1ns / 1ps
// Testbench for quaternion_rotate_vector: directed and random rotations checked
// against a fixed-point predictor held in a small scoreboard class.
// Depends on qrv_pkg and the quaternion_rotate_vector RTL.
module tb_quaternion_rotate_vector;

  localparam int QW = qrv_pkg::Q_W;
  localparam int VW = qrv_pkg::VEC_W;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    qrv_pkg::vec_t rot;
    logic sat;
  } rotation_t;

  class rotation_checker;
    rotation_t pending_rotations[$];
    int unsigned accepted;
    int unsigned checked;
    int unsigned clipped;
    int unsigned mismatches;

    function automatic rotation_t rotate_vector(quat_t q, qrv_pkg::vec_t v);
      longint w;
      longint x;
      longint y;
      longint z;
      longint unity;
      longint mat[3][3];
      longint vin[3];
      longint acc;
      longint r[3];
      rotation_t res;
      w = $signed(q.w);
      x = $signed(q.x);
      y = $signed(q.y);
      z = $signed(q.z);
      vin[0] = $signed(v.x);
      vin[1] = $signed(v.y);
      vin[2] = $signed(v.z);
      unity = longint'(1) << qrv_pkg::FRAC_BITS;
      mat[0][0] = unity - (2 * y * y + 2 * z * z);
      mat[0][1] = 2 * x * y - 2 * w * z;
      mat[0][2] = 2 * x * z + 2 * w * y;
      mat[1][0] = 2 * x * y + 2 * w * z;
      mat[1][1] = unity - (2 * x * x + 2 * z * z);
      mat[1][2] = 2 * y * z - 2 * w * x;
      mat[2][0] = 2 * x * z - 2 * w * y;
      mat[2][1] = 2 * y * z + 2 * w * x;
      mat[2][2] = unity - (2 * x * x + 2 * y * y);
      res.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc = mat[i][0] * vin[0] + mat[i][1] * vin[1] + mat[i][2] * vin[2];
        acc = acc + (longint'(1) << (qrv_pkg::FRAC_BITS - 1));
        r[i] = acc >>> qrv_pkg::FRAC_BITS;
        if (r[i] > 64'sd8388607) begin
          r[i] = 64'sd8388607;
          res.sat = 1'b1;
        end
        if (r[i] < -64'sd8388608) begin
          r[i] = -64'sd8388608;
          res.sat = 1'b1;
        end
      end
      res.rot.x = r[0][VW-1:0];
      res.rot.y = r[1][VW-1:0];
      res.rot.z = r[2][VW-1:0];
      return res;
    endfunction

    function void note_input(quat_t q, qrv_pkg::vec_t v);
      pending_rotations.push_back(rotate_vector(q, v));
      accepted++;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at result %0d: %s", checked, what);
      mismatches++;
    endtask

    task check_result(rotation_t got);
      rotation_t want;
      if (pending_rotations.size() == 0) begin
        report_mismatch("result arrived with no rotation pending");
      end else begin
        want = pending_rotations.pop_front();
        if (got.rot.x !== want.rot.x)
          report_mismatch($sformatf("rot_x got %0d expected %0d", got.rot.x, want.rot.x));
        if (got.rot.y !== want.rot.y)
          report_mismatch($sformatf("rot_y got %0d expected %0d", got.rot.y, want.rot.y));
        if (got.rot.z !== want.rot.z)
          report_mismatch($sformatf("rot_z got %0d expected %0d", got.rot.z, want.rot.z));
        if (got.sat !== want.sat)
          report_mismatch($sformatf("saturated got %0b expected %0b", got.sat, want.sat));
        if (want.sat)
          clipped++;
      end
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [QW-1:0] in_quat_w;
  logic signed [QW-1:0] in_quat_x;
  logic signed [QW-1:0] in_quat_y;
  logic signed [QW-1:0] in_quat_z;
  logic signed [VW-1:0] in_vec_x;
  logic signed [VW-1:0] in_vec_y;
  logic signed [VW-1:0] in_vec_z;
  logic out_valid;
  logic signed [VW-1:0] out_rot_x;
  logic signed [VW-1:0] out_rot_y;
  logic signed [VW-1:0] out_rot_z;
  logic out_saturated;

  rotation_checker sb = new();
  int unsigned directed_count;
  int unsigned drain_count;
  int unsigned longest_gap;

  quaternion_rotate_vector dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_quat_w     (in_quat_w),
    .in_quat_x     (in_quat_x),
    .in_quat_y     (in_quat_y),
    .in_quat_z     (in_quat_z),
    .in_vec_x      (in_vec_x),
    .in_vec_y      (in_vec_y),
    .in_vec_z      (in_vec_z),
    .out_valid     (out_valid),
    .out_rot_x     (out_rot_x),
    .out_rot_y     (out_rot_y),
    .out_rot_z     (out_rot_z),
    .out_saturated (out_saturated)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_input(quat_t'({in_quat_w, in_quat_x, in_quat_y, in_quat_z}),
                      qrv_pkg::vec_t'({in_vec_x, in_vec_y, in_vec_z}));
      if (out_valid)
        sb.check_result(rotation_t'({out_rot_x, out_rot_y, out_rot_z, out_saturated}));
    end
  end

  function automatic logic signed [QW-1:0] pick_quat_part(int unsigned kind);
    if (kind == 3)
      kind = $urandom_range(0, 2);
    case (kind)
      0: return QW'($urandom);
      1: return QW'($urandom_range(0, 23170) - 11585);
      default: begin
        case ($urandom_range(0, 5))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          3: return -16'sd1;
          4: return 16'sd16384;
          default: return -16'sd16384;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [VW-1:0] pick_vec_part(int unsigned kind);
    if (kind == 3)
      kind = $urandom_range(0, 2);
    case (kind)
      0: return VW'($urandom);
      1: return VW'($urandom_range(0, 2000) - 1000);
      default: begin
        case ($urandom_range(0, 4))
          0: return -24'sd8388608;
          1: return 24'sd8388607;
          2: return 24'sd0;
          3: return -24'sd1;
          default: return 24'sd1;
        endcase
      end
    endcase
  endfunction

  task send_rotation(input int qw, input int qx, input int qy, input int qz,
                     input int vx, input int vy, input int vz);
    @(negedge clk);
    start = 1'b1;
    in_quat_w = qw[QW-1:0];
    in_quat_x = qx[QW-1:0];
    in_quat_y = qy[QW-1:0];
    in_quat_z = qz[QW-1:0];
    in_vec_x = vx[VW-1:0];
    in_vec_y = vy[VW-1:0];
    in_vec_z = vz[VW-1:0];
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  // Drives junk on the data inputs while start is low.
  task rest(input int unsigned cycles);
    if (cycles != 0) begin
      if (cycles > longest_gap)
        longest_gap = cycles;
      @(negedge clk);
      start = 1'b0;
      in_quat_w = QW'($urandom);
      in_quat_x = QW'($urandom);
      in_quat_y = QW'($urandom);
      in_quat_z = QW'($urandom);
      in_vec_x = VW'($urandom);
      in_vec_y = VW'($urandom);
      in_vec_z = VW'($urandom);
      repeat (cycles - 1)
        @(negedge clk);
    end
  endtask

  task drain_pipeline();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_rotations.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    drain_count++;
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned mode;
    int unsigned qkind;
    int unsigned vkind;
    int unsigned gap;
    start = 1'b0;
    rst_n = 1'b0;
    in_quat_w = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    in_vec_x = '0;
    in_vec_y = '0;
    in_vec_z = '0;
    directed_count = 0;
    drain_count = 0;
    longest_gap = 0;
    repeat (9)
      @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Identity, zero and axis rotations, half-scale ties, and the -2.0 component.
    send_rotation(16384, 0, 0, 0, 8388607, -8388608, 0);
    send_rotation(16384, 0, 0, 0, -1, 1, 0);
    send_rotation(16384, 0, 0, 0, -8388608, -8388608, -8388608);
    send_rotation(0, 0, 0, 0, 5, -7, 8388607);
    rest(3);
    send_rotation(11585, 0, 0, 11585, 1000000, 0, -1000000);
    send_rotation(0, 16384, 0, 0, 8388607, 8388607, -8388608);
    send_rotation(15137, 0, 6270, 0, 4000000, -123457, 8388607);
    send_rotation(0, 0, 0, 8192, 1, -1, 3);
    send_rotation(0, 0, 0, 8192, -3, 8388607, -8388608);
    rest(1);
    send_rotation(-32768, 0, 0, 0, 8388607, -8388608, 12345);
    send_rotation(0, -32768, 0, 0, 1, 1, 1);
    send_rotation(0, 0, -32768, 0, -1, 100, 8388607);
    send_rotation(0, 0, 0, -32768, 8388607, 8388607, 8388607);
    send_rotation(-32768, -32768, -32768, -32768, 8388607, 8388607, 8388607);
    send_rotation(32767, 32767, 32767, 32767, -8388608, -8388608, -8388608);
    send_rotation(32767, -32768, 32767, -32768, -1, -1, -1);
    send_rotation(100, 200, -300, 400, 8000000, -7000000, 6000000);
    send_rotation(-32768, 32767, -32768, 32767, 0, 0, 0);
    directed_count = 18;
    drain_pipeline();

    burst_left = 0;
    for (int i = 0; i < 2000; i++) begin
      mode = $urandom_range(0, 9);
      qkind = (mode < 4) ? 0 : (mode < 7) ? 1 : (mode == 7) ? 2 : (mode == 8) ? 3 : 1;
      vkind = (mode < 7) ? 0 : (mode == 7) ? 2 : (mode == 8) ? 3 : 1;
      send_rotation(int'(pick_quat_part(qkind)), int'(pick_quat_part(qkind)),
                    int'(pick_quat_part(qkind)), int'(pick_quat_part(qkind)),
                    int'(pick_vec_part(vkind)), int'(pick_vec_part(vkind)),
                    int'(pick_vec_part(vkind)));
      if (i % 500 == 499) begin
        drain_pipeline();
      end else if (burst_left != 0) begin
        burst_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        burst_left = $urandom_range(5, 40);
      end else begin
        gap = $urandom_range(0, 99);
        if (gap < 50)
          rest(0);
        else if (gap < 92)
          rest($urandom_range(1, 3));
        else
          rest($urandom_range(8, 40));
      end
    end

    drain_pipeline();
    repeat (8)
      @(posedge clk);
    if (sb.pending_rotations.size() != 0)
      sb.report_mismatch($sformatf("%0d rotations never produced a result",
                                   sb.pending_rotations.size()));

    $display("Rotations: %0d accepted (%0d directed), %0d checked, %0d saturated.",
             sb.accepted, directed_count, sb.checked, sb.clipped);
    $display("Input gaps up to %0d cycles, %0d full drains, %0d mismatches.",
             longest_gap, drain_count, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d rotations still pending.", sb.pending_rotations.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
